/* rtl/spt_pkg.sv */
// Shared types and constants for the sorted position table floor lookup.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package spt_pkg;

    // Default sizing, used as the defaults of the top level parameters.
    localparam int DEF_TABLE_DEPTH   = 64;
    localparam int DEF_POSITION_BITS = 24;

    // Fixed result field widths.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int ROW_W    = 6;

    // Command codes. The two upper codes both move the cursor.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_MOVE     = 2'd2,
        CMD_MOVE_ALT = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_MOVED     = 3'd5
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FLOOR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new command and position
        logic update;   // compare and shift the table, update count and cursor
        logic resolve;  // find the floor row and strobe the result
    } dp_cmd_t;

endpackage

/* rtl/spt_ctrl.sv */
// Controller state machine for the sorted position table floor lookup.
// Depends on spt_pkg for the state and datapath command types.
module spt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output spt_pkg::dp_cmd_t dp_cmd
);

    spt_pkg::state_t state_reg;
    spt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new transaction may enter while the previous one resolves its floor.
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        busy       = 1'b0;
        unique case (state_reg)
            spt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = spt_pkg::S_SHIFT;
                end
            end
            spt_pkg::S_SHIFT:
            begin
                busy          = 1'b1;
                dp_cmd.update = 1'b1;
                state_next    = spt_pkg::S_FLOOR;
            end
            spt_pkg::S_FLOOR:
            begin
                dp_cmd.resolve = 1'b1;
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = spt_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = spt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/spt_datapath.sv */
// Datapath: a row of compare-and-shift key cells, entry count, cursor and floor encoder.
// Depends on spt_pkg for command, status and datapath command types.
module spt_datapath
#(
    parameter int TABLE_DEPTH   = spt_pkg::DEF_TABLE_DEPTH,
    parameter int POSITION_BITS = spt_pkg::DEF_POSITION_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  spt_pkg::dp_cmd_t              dp_cmd,
    input  logic [spt_pkg::CMD_W-1:0]     cmd,
    input  logic [POSITION_BITS-1:0]      position,
    output logic [spt_pkg::STATUS_W-1:0]  status,
    output logic [spt_pkg::COUNT_W-1:0]   entry_count,
    output logic                          floor_valid,
    output logic [spt_pkg::ROW_W-1:0]     floor_row,
    output logic                          done
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    spt_pkg::cmd_t              cmd_reg;
    logic [POSITION_BITS-1:0]   pos_reg;
    logic [POSITION_BITS-1:0]   cursor_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    spt_pkg::status_t           status_reg;
    spt_pkg::status_t           status_next;
    logic                       done_reg;
    logic                       floor_valid_reg;
    logic [IDX_W-1:0]           floor_idx_reg;
    logic [IDX_W-1:0]           floor_idx_next;

    logic [POSITION_BITS-1:0]   key_reg  [TABLE_DEPTH];
    logic [POSITION_BITS-1:0]   key_next [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]     lt;
    logic [TABLE_DEPTH-1:0]     eq;
    logic [TABLE_DEPTH-1:0]     le;
    logic [TABLE_DEPTH-1:0]     is_floor;
    logic                       hit;
    logic                       full;
    logic                       do_insert;
    logic                       do_remove;

    logic [CNT_W+spt_pkg::COUNT_W-1:0] count_ext;
    logic [IDX_W+spt_pkg::ROW_W-1:0]   row_ext;

    // Per-cell compares against the command position and the cursor.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            lt[i] = (count_reg > CNT_W'(i)) && (key_reg[i] <  pos_reg);
            eq[i] = (count_reg > CNT_W'(i)) && (key_reg[i] == pos_reg);
            le[i] = (count_reg > CNT_W'(i)) && (key_reg[i] <= cursor_reg);
        end
    end

    assign hit  = |eq;
    assign full = (count_reg == FULL_COUNT);

    always_comb
    begin
        status_next = spt_pkg::ST_MOVED;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        unique case (cmd_reg)
            spt_pkg::CMD_INSERT:
            begin
                if (hit)
                begin
                    status_next = spt_pkg::ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = spt_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spt_pkg::ST_INSERTED;
                    do_insert   = 1'b1;
                end
            end
            spt_pkg::CMD_REMOVE:
            begin
                if (hit)
                begin
                    status_next = spt_pkg::ST_REMOVED;
                    do_remove   = 1'b1;
                end
                else
                begin
                    status_next = spt_pkg::ST_NOT_FOUND;
                end
            end
            spt_pkg::CMD_MOVE, spt_pkg::CMD_MOVE_ALT:
            begin
                status_next = spt_pkg::ST_MOVED;
            end
            default:
            begin
                status_next = spt_pkg::ST_MOVED;
            end
        endcase
    end

    // Each cell keeps its key when it lies below the position; otherwise an insert
    // gives it the new key at the boundary or the key below; a remove, the key above.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            key_next[i] = key_reg[i];
            if (!lt[i])
            begin
                if (do_insert)
                begin
                    if (i == 0)
                    begin
                        key_next[i] = pos_reg;
                    end
                    else if (lt[(i > 0) ? i - 1 : 0])
                    begin
                        key_next[i] = pos_reg;
                    end
                    else
                    begin
                        key_next[i] = key_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                else if (do_remove && (i < TABLE_DEPTH - 1))
                begin
                    key_next[i] = key_reg[(i < TABLE_DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // The floor is the last set cell of the thermometer le.
    always_comb
    begin
        floor_idx_next = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            is_floor[i] = le[i] && ((i == TABLE_DEPTH - 1) ||
                          !le[(i < TABLE_DEPTH - 1) ? i + 1 : i]);
            floor_idx_next = floor_idx_next | (is_floor[i] ? IDX_W'(i) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.update)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
        if (dp_cmd.load)
        begin
            cmd_reg <= spt_pkg::cmd_t'(cmd);
            pos_reg <= position;
        end
        if (dp_cmd.update)
        begin
            status_reg <= status_next;
        end
        if (dp_cmd.resolve)
        begin
            floor_valid_reg <= le[0];
            floor_idx_reg   <= floor_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= dp_cmd.resolve;
            if (dp_cmd.update)
            begin
                count_reg <= count_next;
                if (cmd_reg[1])
                begin
                    cursor_reg <= pos_reg;
                end
            end
        end
    end

    assign count_ext   = (CNT_W + spt_pkg::COUNT_W)'(count_reg);
    assign row_ext     = (IDX_W + spt_pkg::ROW_W)'(floor_idx_reg);
    assign status      = status_reg;
    assign entry_count = count_ext[spt_pkg::COUNT_W-1:0];
    assign floor_valid = floor_valid_reg;
    assign floor_row   = row_ext[spt_pkg::ROW_W-1:0];
    assign done        = done_reg;

endmodule

/* rtl/sorted_position_table_floor_lookup.sv */
// An accepted transaction passes through the shift state (compare-and-shift over the key cells)
// and the floor state (floor encode); its result, marked by done, is registered as the floor
// state ends. A new one may enter in the floor state; start may be raised while done is shown.
// Reset (rst_n low, asynchronous): empty table, cursor at zero, no result pending.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
module sorted_position_table_floor_lookup
#(
    parameter int TABLE_DEPTH   = spt_pkg::DEF_TABLE_DEPTH,
    parameter int POSITION_BITS = spt_pkg::DEF_POSITION_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spt_pkg::CMD_W-1:0]     cmd,
    input  logic [POSITION_BITS-1:0]      position,
    output logic                          done,
    output logic [spt_pkg::STATUS_W-1:0]  status,
    output logic [spt_pkg::COUNT_W-1:0]   entry_count,
    output logic                          floor_valid,
    output logic [spt_pkg::ROW_W-1:0]     floor_row
);

    // The controller sequences each transaction through a shift cycle, in which
    // every key cell compares itself with the position and moves at once, and
    // a floor cycle, in which the settled table is compared with the cursor.
    spt_pkg::dp_cmd_t dp_cmd;

    spt_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .dp_cmd (dp_cmd)
    );

    // The datapath holds the key cells, the entry count, the cursor and the
    // result registers. Status and entry count stay stable while done is high
    // because the next transaction only changes them at the end of its shift.
    spt_datapath
    #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .cmd         (cmd),
        .position    (position),
        .status      (status),
        .entry_count (entry_count),
        .floor_valid (floor_valid),
        .floor_row   (floor_row),
        .done        (done)
    );

    // An accepted transaction always enters the shift cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter the shift cycle");

    // The shift cycle lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("shift cycle lasted more than one cycle");

    // Every shift is followed by a floor resolve, which gives the strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.update |=> (dp_cmd.resolve ##1 done))
        else $error("shift was not followed by a resolved result");

    // A result strobe is never shown unless a shift came before the floor resolve that gave it.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dp_cmd.update, 2))
        else $error("result strobe without a matching transaction");

endmodule

/* verif/spt_tb_pkg.sv */
// Scoreboard for the sorted position table floor lookup testbench.
// It keeps its own copy of the key table and the cursor and predicts each result.
// Depends on rtl/spt_pkg.sv for the command and status codes and the field widths.
package spt_tb_pkg;

    import spt_pkg::*;

    localparam int TBL_DEPTH   = DEF_TABLE_DEPTH;
    localparam int POS_W       = DEF_POSITION_BITS;
    localparam int MAX_REPORTS = 10;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        status_t             st;
        logic [COUNT_W-1:0]  count;
        logic                fv;
        logic [ROW_W-1:0]    row;
    } floor_result_t;

    class floor_lookup_scoreboard;

        pos_t          keys [TBL_DEPTH];
        int            n_keys;
        pos_t          cursor;
        floor_result_t expected_q [$];
        int unsigned   mismatches;

        function new();
            n_keys     = 0;
            cursor     = '0;
            mismatches = 0;
            foreach (keys[i])
            begin
                keys[i] = '0;
            end
        endfunction

        // Applies one accepted transaction to the shadow table and queues its result.
        function void note_command(cmd_t op, pos_t key);
            int            row;
            int            not_above;
            bit            hit;
            floor_result_t r;
            if (op == CMD_MOVE || op == CMD_MOVE_ALT)
            begin
                cursor = key;
                r.st   = ST_MOVED;
            end
            else
            begin
                row = 0;
                while (row < n_keys && keys[row] < key)
                begin
                    row++;
                end
                hit = (row < n_keys) && (keys[row] == key);
                if (op == CMD_INSERT)
                begin
                    if (hit)
                    begin
                        r.st = ST_PRESENT;
                    end
                    else if (n_keys >= TBL_DEPTH)
                    begin
                        r.st = ST_FULL;
                    end
                    else
                    begin
                        for (int i = n_keys; i > row; i--)
                        begin
                            keys[i] = keys[i-1];
                        end
                        keys[row] = key;
                        n_keys++;
                        r.st = ST_INSERTED;
                    end
                end
                else if (hit)
                begin
                    for (int i = row; i < n_keys - 1; i++)
                    begin
                        keys[i] = keys[i+1];
                    end
                    n_keys--;
                    r.st = ST_REMOVED;
                end
                else
                begin
                    r.st = ST_NOT_FOUND;
                end
            end
            not_above = 0;
            while (not_above < n_keys && keys[not_above] <= cursor)
            begin
                not_above++;
            end
            r.count = COUNT_W'(n_keys);
            r.fv    = (not_above > 0);
            r.row   = (not_above > 0) ? ROW_W'(not_above - 1) : '0;
            expected_q.push_back(r);
        endfunction

        // Compares one strobed result with the oldest outstanding prediction.
        function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] count,
                                   logic fv, logic [ROW_W-1:0] row);
            floor_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with no transaction outstanding: status %0d count %0d floor %0b/%0d",
                             st, count, fv, row);
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.st || count !== want.count || fv !== want.fv || row !== want.row)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result mismatch: expected status %0d count %0d floor %0b/%0d, got status %0d count %0d floor %0b/%0d",
                             want.st, want.count, want.fv, want.row, st, count, fv, row);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Returns a key that is in the table now; the caller makes sure the table is not empty.
        function pos_t pick_stored();
            return keys[$urandom_range(0, n_keys - 1)];
        endfunction

    endclass

endpackage

/* verif/tb_sorted_position_table_floor_lookup.sv */
// Self-checking testbench for the sorted position table floor lookup block.
// Drives directed and random insert, remove and move transactions and checks every result.
// Depends on rtl/spt_pkg.sv, the block itself and verif/spt_tb_pkg.sv.
module tb_sorted_position_table_floor_lookup;

    import spt_pkg::*;
    import spt_tb_pkg::*;

    // A correct run never comes near QUIET_LIMIT without a transaction or a result,
    // since every sender gap is short and every accepted item resolves to a result.
    localparam int QUIET_LIMIT  = 200;
    localparam int RANDOM_ITEMS = 1330;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    pos_t                 position;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   entry_count;
    logic                 floor_valid;
    logic [ROW_W-1:0]     floor_row;

    floor_lookup_scoreboard sb;
    int                     quiet_cycles = 0;

    sorted_position_table_floor_lookup i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .position    (position),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .floor_valid (floor_valid),
        .floor_row   (floor_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Everything is sampled at the rising edge, where the values seen are the ones
    // that held during the cycle that the edge ends. The result is checked before the
    // new transaction is noted, so a result can never be matched to the transaction
    // accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(status, entry_count, floor_valid, floor_row);
            if (start && !busy)
                sb.note_command(cmd, position);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A hang anywhere in the block shows up as a long stretch with no handshake at all.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_sorted_position_table_floor_lookup: done, errors");
        $finish;
    end

    function automatic pos_t rand_pos();
        logic [31:0] raw;
        raw = $urandom();
        return raw[POS_W-1:0];
    endfunction

    // Keys close to a base value give neighbors one apart and cursors that land
    // between entries, which full random keys almost never do.
    function automatic pos_t near_key(pos_t base);
        logic [31:0] raw;
        raw = $urandom_range(0, 255);
        return base + raw[POS_W-1:0];
    endfunction

    // Key for an insert or a remove: a stored key with the given chance, otherwise new.
    function automatic pos_t table_key(pos_t base, int unsigned pct_stored);
        if (sb.n_keys > 0 && $urandom_range(1, 100) <= pct_stored)
            return sb.pick_stored();
        else if ($urandom_range(0, 1) == 1)
            return rand_pos();
        else
            return near_key(base);
    endfunction

    // New cursor: the ends of the range, an entry, just beside an entry, near the base, or anywhere.
    function automatic pos_t cursor_target(pos_t base);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return rand_pos();
            3: return near_key(base);
            4: return (sb.n_keys > 0) ? sb.pick_stored() : rand_pos();
            default:
            begin
                if (sb.n_keys == 0)
                    return rand_pos();
                else if ($urandom_range(0, 1) == 1)
                    return sb.pick_stored() + 1'b1;
                else
                    return sb.pick_stored() - 1'b1;
            end
        endcase
    endfunction

    // Presents one transaction and returns at the edge where it is taken.
    // start stays high on return, so a following transaction goes out back to back.
    task automatic issue_command(input cmd_t op, input pos_t key);
        start    <= 1'b1;
        cmd      <= op;
        position <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Sender gap; the command and position lines carry junk while start is low.
    task automatic hold_off(input int unsigned cycles);
        logic [31:0] raw;
        raw = $urandom();
        start    <= 1'b0;
        cmd      <= cmd_t'(raw[1:0]);
        position <= rand_pos();
        repeat (cycles)
            @(posedge clk);
    endtask

    // Lets the block drain completely before the next transaction.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned round_left;
        int unsigned roll;
        bit          filling;
        bit          in_burst;
        cmd_t        op;
        pos_t        key;
        pos_t        base;

        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = CMD_INSERT;
        position = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. It starts on an empty table, puts both extreme keys and the
        // alternating bit patterns in, walks the cursor over them with both move codes,
        // and takes the table back to empty. Along the way the cursor sits before the
        // first entry with the table empty and with it occupied, and lands exactly on
        // an entry. Inserting into a full table is left to the random fill rounds.
        issue_command(CMD_MOVE,     24'h000000);
        issue_command(CMD_REMOVE,   24'h000005);
        issue_command(CMD_INSERT,   24'hFFFFFF);
        issue_command(CMD_INSERT,   24'h000000);
        issue_command(CMD_INSERT,   24'h000000);
        issue_command(CMD_INSERT,   24'h800000);
        issue_command(CMD_INSERT,   24'h555555);
        issue_command(CMD_INSERT,   24'hAAAAAA);
        issue_command(CMD_MOVE_ALT, 24'h7FFFFF);
        issue_command(CMD_MOVE,     24'hFFFFFF);
        issue_command(CMD_REMOVE,   24'h800000);
        issue_command(CMD_REMOVE,   24'h800001);
        issue_command(CMD_MOVE,     24'h555554);
        issue_command(CMD_REMOVE,   24'h000000);
        issue_command(CMD_MOVE_ALT, 24'h555555);
        issue_command(CMD_INSERT,   24'h555556);
        issue_command(CMD_REMOVE,   24'hFFFFFF);
        issue_command(CMD_REMOVE,   24'hAAAAAA);
        issue_command(CMD_REMOVE,   24'h555556);
        issue_command(CMD_REMOVE,   24'h555555);
        issue_command(CMD_REMOVE,   24'h555555);
        wait_for_results();

        // Random part. Rounds alternate between filling and draining the table, so
        // the table keeps running from empty to full and back. Fill rounds are long
        // enough to hit the full table and then keep pushing new and present keys
        // into it. Each round clusters part of its keys around a base of its own.
        sent       = 0;
        round_left = 0;
        filling    = 1'b0;
        base       = '0;
        while (sent < RANDOM_ITEMS)
        begin
            if (round_left == 0)
            begin
                round_left = $urandom_range(100, 200);
                filling    = !filling;
                base       = rand_pos();
                if ($urandom_range(0, 1) == 1)
                    wait_for_results();
            end

            roll = $urandom_range(1, 100);
            if (filling)
            begin
                if (roll <= 80)
                    op = CMD_INSERT;
                else if (roll <= 88)
                    op = CMD_REMOVE;
                else
                    op = ($urandom_range(0, 1) == 1) ? CMD_MOVE : CMD_MOVE_ALT;
            end
            else
            begin
                if (roll <= 10)
                    op = CMD_INSERT;
                else if (roll <= 85)
                    op = CMD_REMOVE;
                else
                    op = ($urandom_range(0, 1) == 1) ? CMD_MOVE : CMD_MOVE_ALT;
            end

            if (op == CMD_INSERT)
                key = table_key(base, filling ? 20 : 30);
            else if (op == CMD_REMOVE)
                key = table_key(base, filling ? 50 : 80);
            else
                key = cursor_target(base);

            issue_command(op, key);
            sent++;
            round_left--;

            // The sender never pauses in one long burst in the middle of the run.
            in_burst = (sent >= 400) && (sent < 700);
            if (!in_burst && $urandom_range(1, 100) <= 15)
                hold_off($urandom_range(1, 5));
        end

        // Drain, then let the clock run on so that any stray result still shows.
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_sorted_position_table_floor_lookup: done, clean");
        else
            $display("tb_sorted_position_table_floor_lookup: done, errors");
        $finish;
    end

endmodule
